// ----- hdl/adt_pkg.sv -----
// shared types, constants and state codes of the aging descriptor table
// depends on nothing
package adt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RETENTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPTED = 2'd1;

  localparam logic [15:0] RETENTION_RESET = 16'd2000;
  localparam logic [9:0] ACCEPTED_RESET = 10'd1023;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] timestamp_ms;
    logic [15:0] key_id;
    logic [9:0]  type_mask;
    logic [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] hit_payload;
    logic [9:0]  hit_type;
    logic        dropped;
    logic        rejected;
  } out_item_t;

  // classified request as queued between front and back
  typedef struct packed {
    logic        command;
    logic        type_ok;
    logic [31:0] limit;
    logic [31:0] timestamp_ms;
    logic [15:0] key_id;
    logic [9:0]  type_mask;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } req_chan_t;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [15:0] key_id;
    logic [9:0]  type_mask;
    logic [31:0] payload;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXP_RD,
    S_EXP_CHK,
    S_ACT,
    S_SCAN_RD,
    S_SCAN_CHK
  } back_state_t;

endpackage

// ----- hdl/adt_ram.sv -----
// generic single write, single read ram with registered read data
// depends on nothing
module adt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/adt_front.sv -----
// front end: takes requests, classifies them and holds them in a two deep queue
// depends on adt_pkg
module adt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  adt_pkg::in_item_t item,
  input  logic [15:0]       retention_ms,
  input  logic [9:0]        accepted_types,
  output adt_pkg::req_chan_t q_out,
  input  logic              pop
);

  adt_pkg::req_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  adt_pkg::req_t cls;

  assign busy = fill[1];
  assign push = start && !busy;

  // saturating threshold and type acceptance
  always_comb begin
    cls.command = item.command;
    cls.type_ok = (item.type_mask & accepted_types) != 10'd0;
    cls.limit = (item.timestamp_ms > {16'd0, retention_ms}) ?
                item.timestamp_ms - {16'd0, retention_ms} : 32'd0;
    cls.timestamp_ms = item.timestamp_ms;
    cls.key_id = item.key_id;
    cls.type_mask = item.type_mask;
    cls.payload = item.payload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        q[wr_ptr] <= cls;
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  assign q_out.valid = fill != 2'd0;
  assign q_out.req = q[rd_ptr];

endmodule

// ----- hdl/adt_back.sv -----
// back end: expiry, insertion and newest-first lookup over the entry ram
// depends on adt_pkg and adt_ram
module adt_back #(
  parameter int TABLE_DEPTH = adt_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  adt_pkg::req_chan_t q_in,
  output logic               pop,
  output logic               done,
  output adt_pkg::out_item_t result
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

  adt_pkg::back_state_t state, state_next;
  adt_pkg::req_t cur;
  logic [AW:0]   count, count_next;
  logic [AW-1:0] oldest, oldest_next;
  logic [AW-1:0] idx, idx_next;
  logic          res_fire;
  adt_pkg::out_item_t res_next;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  adt_pkg::entry_t wdata, rdata;

  logic [AW:0]   sum_ins, sum_scan;
  logic [AW-1:0] pos_ins, pos_scan, oldest_inc;

  assign sum_ins = {1'b0, oldest} + count;
  assign pos_ins = (sum_ins >= DEPTH_W) ? AW'(sum_ins - DEPTH_W) : sum_ins[AW-1:0];
  assign sum_scan = {1'b0, oldest} + {1'b0, idx};
  assign pos_scan = (sum_scan >= DEPTH_W) ? AW'(sum_scan - DEPTH_W) : sum_scan[AW-1:0];
  assign oldest_inc = (oldest == LAST) ? '0 : oldest + 1'b1;

  adt_ram #(.WIDTH($bits(adt_pkg::entry_t)), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    oldest_next = oldest;
    idx_next = idx;
    pop = 1'b0;
    res_fire = 1'b0;
    res_next = '0;
    we = 1'b0;
    waddr = pos_ins;
    raddr = oldest;
    wdata.time_ms = cur.timestamp_ms;
    wdata.key_id = cur.key_id;
    wdata.type_mask = cur.type_mask;
    wdata.payload = cur.payload;
    case (state)
      adt_pkg::S_IDLE: begin
        if (q_in.valid) begin
          pop = 1'b1;
          state_next = adt_pkg::S_EXP_RD;
        end
      end
      adt_pkg::S_EXP_RD: begin
        state_next = (count == '0) ? adt_pkg::S_ACT : adt_pkg::S_EXP_CHK;
      end
      adt_pkg::S_EXP_CHK: begin
        if (cur.limit > rdata.time_ms) begin
          oldest_next = oldest_inc;
          count_next = count - 1'b1;
          state_next = adt_pkg::S_EXP_RD;
        end else begin
          state_next = adt_pkg::S_ACT;
        end
      end
      adt_pkg::S_ACT: begin
        if (cur.command == adt_pkg::CMD_ADD) begin
          res_fire = 1'b1;
          state_next = adt_pkg::S_IDLE;
          if (!cur.type_ok) begin
            res_next.rejected = 1'b1;
          end else begin
            we = 1'b1;
            if (count == DEPTH_W) begin
              // full: overwrite the oldest slot, which becomes the newest
              waddr = oldest;
              oldest_next = oldest_inc;
              res_next.dropped = 1'b1;
            end else begin
              count_next = count + 1'b1;
            end
          end
        end else if (count == '0) begin
          res_fire = 1'b1;
          state_next = adt_pkg::S_IDLE;
        end else begin
          idx_next = AW'(count - 1'b1);
          state_next = adt_pkg::S_SCAN_RD;
        end
      end
      adt_pkg::S_SCAN_RD: begin
        raddr = pos_scan;
        state_next = adt_pkg::S_SCAN_CHK;
      end
      adt_pkg::S_SCAN_CHK: begin
        if (rdata.key_id == cur.key_id && (rdata.type_mask & cur.type_mask) != 10'd0) begin
          res_fire = 1'b1;
          res_next.hit = 1'b1;
          res_next.hit_payload = rdata.payload;
          res_next.hit_type = rdata.type_mask;
          state_next = adt_pkg::S_IDLE;
        end else if (idx == '0) begin
          res_fire = 1'b1;
          state_next = adt_pkg::S_IDLE;
        end else begin
          idx_next = idx - 1'b1;
          state_next = adt_pkg::S_SCAN_RD;
        end
      end
      default: begin
        state_next = adt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adt_pkg::S_IDLE;
      count <= '0;
      oldest <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      oldest <= oldest_next;
      done <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (pop) begin
      cur <= q_in.req;
    end
    if (res_fire) begin
      result <= res_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_W)
    else $error("entry count beyond table depth");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == adt_pkg::S_IDLE && q_in.valid)
    else $error("pop outside idle");
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.hit && (result.dropped || result.rejected)))
    else $error("hit together with add flags");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results back to back");

endmodule

// ----- hdl/aging_descriptor_table_unit.sv -----
// top level of the aging descriptor table: config registers, front and back
// depends on adt_pkg, adt_front, adt_back, adt_ram
//
// usage
//   request channel: a request is taken at a rising edge with start high and
//   busy low. the front end queues up to two requests; busy is high while
//   that queue is full.
//   config channel: cfg_ready is always high; index 0 writes retention_ms,
//   index 1 writes accepted_types, other indexes are ignored. write only
//   while no request is outstanding.
//   result: done is high for exactly one cycle with the result on result;
//   the receiver cannot stall, so no backpressure exists on this side.
// sequencing
//   the back end retires expired entries oldest first, then an add writes
//   unless rejected and a lookup scans newest first until a match (at most
//   the fill). one request at a time in the back end, the next taken the
//   cycle after its result is formed.
// reset
//   synchronous rst empties the table and queue and restores the register
//   defaults; the ram holds no reset and is only read where written.
module aging_descriptor_table_unit #(
  parameter int TABLE_DEPTH = adt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  adt_pkg::in_item_t                item,
  output logic                             done,
  output adt_pkg::out_item_t               result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [adt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [adt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [15:0] retention_ms;
  logic [9:0]  accepted_types;
  adt_pkg::req_chan_t q_chan;
  logic pop;

  assign cfg_ready = 1'b1;

  // config registers, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      retention_ms <= adt_pkg::RETENTION_RESET;
      accepted_types <= adt_pkg::ACCEPTED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        adt_pkg::CFG_RETENTION: retention_ms <= cfg_data;
        adt_pkg::CFG_ACCEPTED: accepted_types <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // front end: classify and queue
  adt_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .item           (item),
    .retention_ms   (retention_ms),
    .accepted_types (accepted_types),
    .q_out          (q_chan),
    .pop            (pop)
  );

  // back end: table walk and update
  adt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_in   (q_chan),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule
